>>> src/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared constants for the circular deque: depth default, action and status codes
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 8;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned ACTION_W      = 3;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned COUNT_W       = 4;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_PUSH_FRONT = 3'd0;
    localparam t_action ACT_PUSH_BACK  = 3'd1;
    localparam t_action ACT_POP_FRONT  = 3'd2;
    localparam t_action ACT_POP_BACK   = 3'd3;
    localparam t_action ACT_PEEK_FRONT = 3'd4;
    localparam t_action ACT_PEEK_BACK  = 3'd5;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_FULL  = 2'd1;
    localparam t_status STAT_EMPTY = 2'd2;

endpackage

`default_nettype wire

>>> src/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// single-port slot memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WORD_W-1:0]        i_wdata,
    output logic      [WORD_W-1:0]        o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// ring-buffer double-ended queue of signed 32-bit words in a slot memory
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries one action (push front, push
// back, pop front, pop back, peek front, peek back) and yields exactly one
// transaction on the output channel with a status, the word read (zero when
// none) and the fill count after the action. Pushes and rejected actions are
// registered directly; pops and peeks that read a word first pass the read
// state, since the slot memory has registered read data and a single port.
// The next action is taken while a result waits in the output register if
// that register is drained by then. Slot contents are undefined after reset.
`default_nettype none

module circular_deque
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic signed [WORD_W-1:0] i_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [WORD_W-1:0] o_data,
    output logic [COUNT_W-1:0]       o_fill_count
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned OW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic          r_state, n_state;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [OW-1:0] r_occ, n_occ;

    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [WORD_W-1:0]   r_out_data, n_out_data;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic [COUNT_W-1:0]  r_pend_count, n_pend_count;

    logic              in_acc;
    logic              out_free;
    logic              is_empty;
    logic              is_full;
    logic [PW-1:0]     head_prev, head_next, tail_prev, tail_next;
    logic              mem_we, mem_re;
    logic [PW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_rdata;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_empty   = (r_occ == '0);
    assign is_full    = (r_occ >= FULL_OCC);

    assign head_prev = (r_head == '0) ? LAST_IDX : r_head - PW'(1);
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + PW'(1);
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - PW'(1);
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + PW'(1);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_count  = r_out_count;
        n_pend_count = r_pend_count;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_head;

        if (r_state == ST_READ) begin
            n_state      = ST_IDLE;
            n_out_valid  = 1'b1;
            n_out_status = STAT_OK;
            n_out_data   = mem_rdata;
            n_out_count  = r_pend_count;
        end else if (in_acc) begin
            n_out_status = STAT_OK;
            n_out_data   = '0;
            case (i_action)
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    if (is_full) begin
                        n_out_status = STAT_FULL;
                    end else begin
                        mem_we = 1'b1;
                        n_occ  = r_occ + OW'(1);
                        if (is_empty) begin
                            n_head   = '0;
                            n_tail   = '0;
                            mem_addr = '0;
                        end else if (i_action == ACT_PUSH_FRONT) begin
                            n_head   = head_prev;
                            mem_addr = head_prev;
                        end else begin
                            n_tail   = tail_next;
                            mem_addr = tail_next;
                        end
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                    if (is_empty) begin
                        n_out_status = STAT_EMPTY;
                    end else begin
                        mem_re   = 1'b1;
                        n_state  = ST_READ;
                        mem_addr = (i_action == ACT_POP_FRONT ||
                                    i_action == ACT_PEEK_FRONT) ? r_head : r_tail;
                        if (i_action == ACT_POP_FRONT) begin
                            n_occ = r_occ - OW'(1);
                            if (r_occ != OW'(1)) begin
                                n_head = head_next;
                            end
                        end else if (i_action == ACT_POP_BACK) begin
                            n_occ = r_occ - OW'(1);
                            if (r_occ != OW'(1)) begin
                                n_tail = tail_prev;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            n_out_count  = COUNT_W'(n_occ);
            n_pend_count = COUNT_W'(n_occ);
            n_out_valid  = (n_state == ST_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_count  <= n_out_count;
        r_pend_count <= n_pend_count;
    end

    cdq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_value),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_data       = r_out_data;
    assign o_fill_count = r_out_count;

    // read cycle only starts with the output register free
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |-> !r_out_valid)
        else $error("read cycle with output register occupied");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_OCC)
        else $error("occupancy above depth");

    a_occ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_occ))
        else $error("occupancy changed without a transaction");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_full && (i_action == ACT_PUSH_FRONT || i_action == ACT_PUSH_BACK)
        |=> o_out_valid && o_status == STAT_FULL && $stable(r_occ))
        else $error("push into full queue not rejected");

    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_empty && (i_action == ACT_POP_FRONT || i_action == ACT_POP_BACK ||
        i_action == ACT_PEEK_FRONT || i_action == ACT_PEEK_BACK)
        |=> o_out_valid && o_status == STAT_EMPTY && o_data == '0)
        else $error("read of empty queue not rejected");

endmodule

`default_nettype wire
